FILE: src/bssc_pkg.sv
// shared types, constants and modular add for the bounded step sequence counter
// no dependencies; used by bssc_cell, bssc_total and the top level
`default_nettype none

package bssc_pkg;

	localparam int unsigned COUNT_W = 30;
	localparam int unsigned ELEM_W  = 8;
	localparam int unsigned LIMIT_W = 8;
	localparam int unsigned ADDR_W  = 3;
	localparam int unsigned DATA_W  = 32;

	localparam logic [COUNT_W:0]   MODULUS     = 31'd1000000007;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd128;

	// register index taken from paddr[2]
	localparam logic REG_VALUE_LIMIT = 1'b0;

	typedef logic [COUNT_W-1:0] count_t;

	// per cell control, built at the top level
	typedef struct packed {
		logic upd;        // accepted item updates the count
		logic first;      // item starts a new sequence
		logic keep;       // value allowed for this item
		logic use_left;   // lower neighbor joins the sum
		logic use_right;  // upper neighbor joins the sum
		logic load;       // copy new count into the drain register
		logic shift;      // drain register takes its upper neighbor
	} cell_ctrl_t;

	// status of the total unit
	typedef struct packed {
		logic busy;
		logic shift;
	} drain_stat_t;

	typedef enum logic [1:0] {
		DS_IDLE,
		DS_DRAIN,
		DS_DONE
	} drain_state_t;

	// sum of two residues, reduced once
	function automatic count_t add_mod(input count_t a, input count_t b);
		logic [COUNT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= MODULUS) begin
			return COUNT_W'(s - MODULUS);
		end
		return s[COUNT_W-1:0];
	endfunction

endpackage

`default_nettype wire

FILE: src/bssc_cell.sv
// one count cell: holds the count for a single value and one drain register
// depends on bssc_pkg
`default_nettype none

module bssc_cell (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire bssc_pkg::cell_ctrl_t ctrl,
	input  wire bssc_pkg::count_t    left_count,
	input  wire bssc_pkg::count_t    right_count,
	input  wire bssc_pkg::count_t    drain_in,
	output bssc_pkg::count_t         count,
	output bssc_pkg::count_t         drain_out
);

	bssc_pkg::count_t count_q;
	bssc_pkg::count_t drain_q;
	bssc_pkg::count_t left_term;
	bssc_pkg::count_t right_term;
	bssc_pkg::count_t partial;
	bssc_pkg::count_t next_count;

	// three point sum of own count and neighbors, one on a first item, masked to the allowed value
	always_comb begin
		left_term  = ctrl.use_left  ? left_count  : '0;
		right_term = ctrl.use_right ? right_count : '0;
		partial    = bssc_pkg::add_mod(left_term, count_q);
		if (!ctrl.keep) begin
			next_count = '0;
		end else if (ctrl.first) begin
			next_count = bssc_pkg::COUNT_W'(1);
		end else begin
			next_count = bssc_pkg::add_mod(partial, right_term);
		end
	end

	// count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.upd) begin
			count_q <= next_count;
		end
	end

	// drain register, shifts toward cell zero
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			drain_q <= next_count;
		end else if (ctrl.shift) begin
			drain_q <= drain_in;
		end
	end

	assign count     = count_q;
	assign drain_out = drain_q;

endmodule

`default_nettype wire

FILE: src/bssc_total.sv
// total unit: accumulates the drained counts and holds the result for output
// depends on bssc_pkg
`default_nettype none

module bssc_total #(
	parameter int unsigned MAX_VAL = 128
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire bssc_pkg::count_t     drain_head,
	input  wire logic                 out_ready,
	output logic                      out_valid,
	output bssc_pkg::count_t          total_count,
	output bssc_pkg::drain_stat_t     stat
);

	localparam int unsigned CNT_W = (MAX_VAL > 1) ? $clog2(MAX_VAL) : 1;
	localparam logic [CNT_W-1:0] CNT_END = CNT_W'(MAX_VAL - 1);

	bssc_pkg::drain_state_t state_q, state_d;
	logic [CNT_W-1:0]       cnt_q;
	bssc_pkg::count_t       acc_q;
	bssc_pkg::count_t       total_q;
	logic                   out_valid_q;
	logic                   out_load;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bssc_pkg::DS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and outputs
	always_comb begin
		state_d    = state_q;
		out_load   = 1'b0;
		stat.busy  = 1'b1;
		stat.shift = 1'b0;
		unique case (state_q)
			bssc_pkg::DS_IDLE: begin
				stat.busy = 1'b0;
				if (start) begin
					state_d = bssc_pkg::DS_DRAIN;
				end
			end
			bssc_pkg::DS_DRAIN: begin
				stat.shift = 1'b1;
				if (cnt_q == CNT_END) begin
					state_d = bssc_pkg::DS_DONE;
				end
			end
			bssc_pkg::DS_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = bssc_pkg::DS_IDLE;
				end
			end
			default: begin
				state_d = bssc_pkg::DS_IDLE;
			end
		endcase
	end

	// drain counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= '0;
		end else if (stat.shift) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	// running total of the drained counts
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
		end else if (stat.shift) begin
			acc_q <= bssc_pkg::add_mod(acc_q, drain_head);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			total_q <= acc_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign total_count = total_q;

endmodule

`default_nettype wire

FILE: src/bounded_step_sequence_counter_core.sv
// top level of the bounded step sequence counter: register port, cell row, total unit
// depends on bssc_pkg, bssc_cell and bssc_total
`default_nettype none

// Counts sequences over 1..value_limit whose neighboring values differ by at
// most one, modulo 1000000007. A row of MAX_VAL cells holds one count per value;
// every accepted item updates all cells at once from their neighbors, so items
// without last are taken one per cycle. An item with last loads the new counts
// into a drain chain that shifts one count per cycle into an accumulator: the
// block then takes no item until the drain ends and the total is loaded into
// the output register, which waits while the previous result is not taken;
// total_count is then offered. element_value 0 is a wildcard; value_limit is
// written over APB at address 0; its effective value saturates at MAX_VAL.
module bounded_step_sequence_counter_core #(
	parameter int unsigned MAX_VAL = 128
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [bssc_pkg::ADDR_W-1:0]    paddr,
	input  wire logic [bssc_pkg::DATA_W-1:0]    pwdata,
	output logic [bssc_pkg::DATA_W-1:0]         prdata,
	output logic                                pready,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [bssc_pkg::ELEM_W-1:0]    element_value,
	input  wire logic                           first,
	input  wire logic                           last,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [bssc_pkg::COUNT_W-1:0]        total_count
);

	localparam int unsigned CLOG_V = $clog2(MAX_VAL + 1);
	localparam int unsigned CMP_W  = (CLOG_V > bssc_pkg::LIMIT_W) ? CLOG_V : bssc_pkg::LIMIT_W;

	logic [bssc_pkg::LIMIT_W-1:0] value_limit_q;
	logic [CMP_W-1:0]             lim;
	logic [CMP_W-1:0]             elem_ext;
	logic                         elem_zero;
	logic                         elem_ok;
	logic                         accept;
	logic                         reg_sel;
	bssc_pkg::drain_stat_t        stat;
	bssc_pkg::count_t             cnt_w   [MAX_VAL];
	bssc_pkg::count_t             drain_w [MAX_VAL];

	// register write on the access phase
	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == bssc_pkg::REG_VALUE_LIMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_limit_q <= bssc_pkg::LIMIT_RESET;
		end else if (psel && penable && pwrite && reg_sel) begin
			value_limit_q <= pwdata[bssc_pkg::LIMIT_W-1:0];
		end
	end

	// register read
	always_comb begin
		prdata = '0;
		if (reg_sel) begin
			prdata = bssc_pkg::DATA_W'(value_limit_q);
		end
	end

	// effective limit and element checks
	always_comb begin
		if (CMP_W'(value_limit_q) > CMP_W'(MAX_VAL)) begin
			lim = CMP_W'(MAX_VAL);
		end else begin
			lim = CMP_W'(value_limit_q);
		end
		elem_ext  = CMP_W'(element_value);
		elem_zero = (element_value == '0);
		elem_ok   = (elem_ext <= lim);
	end

	assign in_ready = !stat.busy;
	assign accept   = in_valid && in_ready;

	// row of count cells
	for (genvar j = 0; j < MAX_VAL; j++) begin : g_cell
		localparam logic [CMP_W-1:0] VAL = CMP_W'(j + 1);

		bssc_pkg::cell_ctrl_t ctrl;
		bssc_pkg::count_t     left_count;
		bssc_pkg::count_t     right_count;
		bssc_pkg::count_t     drain_in;

		if (j > 0) begin : g_left
			assign left_count = cnt_w[j-1];
		end else begin : g_no_left
			assign left_count = '0;
		end

		if (j < MAX_VAL - 1) begin : g_right
			assign right_count = cnt_w[j+1];
			assign drain_in    = drain_w[j+1];
		end else begin : g_no_right
			assign right_count = '0;
			assign drain_in    = '0;
		end

		always_comb begin
			ctrl.upd       = accept;
			ctrl.first     = first;
			ctrl.keep      = elem_ok && (VAL <= lim) && (elem_zero || (elem_ext == VAL));
			ctrl.use_left  = (j > 0);
			ctrl.use_right = (VAL < lim);
			ctrl.load      = accept && last;
			ctrl.shift     = stat.shift;
		end

		bssc_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.left_count  (left_count),
			.right_count (right_count),
			.drain_in    (drain_in),
			.count       (cnt_w[j]),
			.drain_out   (drain_w[j])
		);
	end

	// total over the drain chain
	bssc_total #(
		.MAX_VAL (MAX_VAL)
	) u_total (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (accept && last),
		.drain_head  (drain_w[0]),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.total_count (total_count),
		.stat        (stat)
	);

`ifndef SYNTHESIS
	// a last transfer closes the input until the total is formed
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && last |=> !in_ready)
		else $error("input open right after a last transfer");

	// results are always reduced residues
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ({1'b0, total_count} < bssc_pkg::MODULUS))
		else $error("total not reduced");

	// the count held in cell zero stays reduced
	assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |-> ({1'b0, cnt_w[0]} < bssc_pkg::MODULUS))
		else $error("cell count not reduced");
`endif

endmodule

`default_nettype wire

FILE: tb/bounded_step_sequence_counter_core_test.sv
// self-checking test of bounded_step_sequence_counter_core: stimulus, total predictor, checks
// depends on bssc_pkg and the core; the scoreboard class sits inside the top module
`timescale 1ns / 1ps

module bounded_step_sequence_counter_core_test;
	localparam int unsigned MAX_VAL = 128;
	localparam int unsigned DRAIN_WAIT = MAX_VAL + 16;
	localparam int unsigned HOLD_CYCLES = 600;
	localparam int unsigned STALL_LIMIT = 4000;

	// holds the per-value counts and the queue of totals still owed by the block
	class seq_count_board;
		localparam int unsigned CELLS = MAX_VAL;
		bssc_pkg::count_t counts[CELLS];
		bssc_pkg::count_t totals_q[$];
		logic [bssc_pkg::LIMIT_W-1:0] limit_reg;
		int unsigned errors;
		int unsigned items_seen;
		int unsigned results_seen;

		function new();
			limit_reg = bssc_pkg::LIMIT_RESET;
			foreach (counts[i]) counts[i] = '0;
			errors = 0;
			items_seen = 0;
			results_seen = 0;
		endfunction

		function void set_limit(logic [bssc_pkg::LIMIT_W-1:0] v);
			limit_reg = v;
		endfunction

		// limit as the block uses it, saturated at the cell count
		function int unsigned limit_eff();
			return (limit_reg > CELLS) ? CELLS : int'(limit_reg);
		endfunction

		function int unsigned pending();
			return totals_q.size();
		endfunction

		// append a total the block still owes
		function void owe_total(bssc_pkg::count_t t);
			totals_q = {totals_q, t};
		endfunction

		// one accepted transfer on the input side: step the counts, owe a total on last
		function void note_item(logic [bssc_pkg::ELEM_W-1:0] elem, logic is_first,
			logic is_last);
			bssc_pkg::count_t nxt[CELLS];
			longint unsigned acc;
			int unsigned lim;
			lim = limit_eff();
			items_seen++;
			foreach (nxt[i]) nxt[i] = '0;
			if (elem <= lim) begin
				for (int unsigned v = 1; v <= lim; v++) begin
					if (elem == 0 || v == elem) begin
						if (is_first) begin
							nxt[v-1] = bssc_pkg::count_t'(1);
						end else begin
							acc = counts[v-1];
							if (v > 1) acc += counts[v-2];
							if (v < lim) acc += counts[v];
							nxt[v-1] = bssc_pkg::count_t'(acc % bssc_pkg::MODULUS);
						end
					end
				end
			end
			counts = nxt;
			if (is_last) begin
				acc = 0;
				for (int unsigned v = 0; v < lim; v++) acc = (acc + counts[v]) % bssc_pkg::MODULUS;
				owe_total(bssc_pkg::count_t'(acc));
			end
		endfunction

		task report(string msg);
			errors++;
			$display("mismatch at %0t: %s", $realtime, msg);
		endtask

		// one accepted transfer on the output side
		task check_total(bssc_pkg::count_t got);
			bssc_pkg::count_t want;
			results_seen++;
			if (totals_q.size() == 0) begin
				report($sformatf("total %0d arrived with nothing expected", got));
				return;
			end
			want = totals_q.pop_front();
			if (got !== want)
				report($sformatf("total_count %0d, expected %0d", got, want));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [bssc_pkg::ADDR_W-1:0] paddr;
	logic [bssc_pkg::DATA_W-1:0] pwdata;
	logic [bssc_pkg::DATA_W-1:0] prdata;
	logic pready;
	logic in_valid;
	logic in_ready;
	logic [bssc_pkg::ELEM_W-1:0] element_value;
	logic first;
	logic last;
	logic out_valid;
	logic out_ready;
	bssc_pkg::count_t total_count;

	// no idling on either side while set
	bit calm;
	// asks the receiver for one long hold-off
	bit hold_request;
	int unsigned idle_cycles;
	int unsigned limits_used;

	seq_count_board board = new();

	bounded_step_sequence_counter_core #(.MAX_VAL(MAX_VAL)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.element_value(element_value),
		.first(first),
		.last(last),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.total_count(total_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// monitor both channels
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) board.check_total(total_count);
			if (in_valid && in_ready) board.note_item(element_value, first, last);
		end
	end

	// watchdog on cycles without any transfer
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= STALL_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", idle_cycles);
				$display("bounded_step_sequence_counter_core_test failed");
				$finish;
			end
		end
	end

	// receiver: random back-pressure, one long hold-off on request
	initial begin
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				out_ready <= 1'b0;
				for (int unsigned held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
			end else begin
				out_ready <= calm || ($urandom_range(99) >= 35);
			end
		end
	end

	// offer one element and wait for its transfer
	task automatic send_item(input int unsigned elem, input bit is_first, input bit is_last);
		while (!calm && $urandom_range(99) < 35) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		element_value <= bssc_pkg::ELEM_W'(elem);
		first <= is_first;
		last <= is_last;
		do @(posedge clk); while (!in_ready);
	endtask

	// let the block finish all owed totals and any pending drain
	task automatic settle();
		in_valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// register write: setup cycle then access cycle
	task automatic write_limit(input int unsigned value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= bssc_pkg::ADDR_W'({bssc_pkg::REG_VALUE_LIMIT, 2'b00});
		pwdata <= bssc_pkg::DATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		board.set_limit(bssc_pkg::LIMIT_W'(value));
		limits_used++;
	endtask

	// mostly legal walks with random wildcards, plus stray single items
	task automatic send_sequences(input int unsigned n_items, input int unsigned max_len);
		int unsigned sent;
		int unsigned len;
		int unsigned walk;
		int unsigned lim;
		int unsigned pick;
		int unsigned elem;
		sent = 0;
		while (sent < n_items) begin
			lim = board.limit_eff();
			if ($urandom_range(99) < 82) begin
				if ($urandom_range(9) == 0) begin
					len = $urandom_range(1, max_len * 3);
				end else begin
					len = $urandom_range(1, max_len);
				end
				walk = (lim == 0) ? 0 : $urandom_range(1, lim);
				for (int unsigned k = 0; k < len; k++) begin
					if (k > 0 && lim > 0) begin
						pick = $urandom_range(2);
						if (pick == 0 && walk > 1) walk--;
						else if (pick == 2 && walk < lim) walk++;
					end
					pick = $urandom_range(99);
					if (pick < 60) elem = 0;
					else if (pick < 94) elem = walk;
					else elem = $urandom_range(MAX_VAL);
					send_item(elem, k == 0, k == len - 1);
				end
				sent += len;
			end else begin
				send_item($urandom_range(MAX_VAL), $urandom_range(1), $urandom_range(1));
				sent++;
			end
		end
	endtask

	initial begin
		int unsigned limit_plan[11];
		int unsigned lim;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		element_value = '0;
		first = 1'b0;
		last = 1'b0;
		calm = 1'b0;
		hold_request = 1'b0;
		limits_used = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset limit, no first yet, single elements, extremes
		send_item(0, 0, 1);
		send_item(0, 1, 1);
		send_item(MAX_VAL, 1, 1);
		send_item(1, 1, 0);
		send_item(0, 0, 0);
		send_item(2, 0, 1);
		send_item(127, 1, 0);
		send_item(MAX_VAL, 0, 0);
		send_item(0, 0, 1);
		send_item(0, 1, 0);
		repeat (4) send_item(0, 0, 0);
		send_item(0, 0, 1);
		send_item(5, 1, 0);
		send_item(5, 1, 1);
		// element above a small limit
		settle();
		write_limit(5);
		send_item(0, 1, 0);
		send_item(7, 0, 1);
		send_item(6, 1, 1);
		// zero limit allows nothing
		settle();
		write_limit(0);
		send_item(0, 1, 1);
		send_item(1, 1, 1);
		// limit above the cell count saturates
		settle();
		write_limit(255);
		send_item(0, 1, 1);
		send_item(MAX_VAL, 1, 1);
		settle();
		write_limit(1);
		send_item(0, 1, 0);
		send_item(1, 0, 1);

		// random phases over a spread of limits
		limit_plan = '{128, 1, 2, 3, 40, 127, 200, 0, 128, 96, 0};
		limit_plan[10] = $urandom_range(1, 255);
		for (int p = 0; p < 11; p++) begin
			settle();
			write_limit(limit_plan[p]);
			lim = board.limit_eff();
			if (p == 4) begin
				// receiver stalls while short sequences keep coming
				hold_request = 1'b1;
				send_sequences(150, 2);
			end else if (p == 8) begin
				calm = 1'b1;
				send_sequences(200, 12);
				calm = 1'b0;
			end else if (lim == 0) begin
				send_sequences(60, 6);
			end else begin
				send_sequences(150, 16);
			end
		end

		settle();
		if (board.pending() != 0) board.report("expected totals never arrived");
		$display("covered %0d elements and %0d totals over %0d limit settings",
			board.items_seen, board.results_seen, limits_used + 1);
		$display("including saturated and zero limits, out-of-range elements and a long output stall");
		if (board.errors == 0) begin
			$display("bounded_step_sequence_counter_core_test passed");
		end else begin
			$display("bounded_step_sequence_counter_core_test failed");
		end
		$finish;
	end
endmodule
